/* design/vok_pkg.sv */
// Package for the voted odometer keeper.
// Holds the mode codes, the limits and the state and result types.
// No dependencies; every other design file imports it.
package vok_pkg;

    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned MAG_W    = 31;
    localparam int unsigned IVAL_W   = 8;
    localparam int unsigned MODE_W   = 3;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT     = 24'd9999999;
    localparam logic [WORD_W-1:0]  COPY_LIMIT      = 32'd16093451;
    localparam logic [WORD_W-1:0]  ALL_ONES        = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0]  MAG_MAX         = 32'h7FFF_FFFF;
    localparam logic [MAG_W-1:0]   NEG_MAG_LIMIT   = 31'h7000_0000;
    localparam logic [IVAL_W-1:0]  INTERVAL_RESET  = 8'd10;

    typedef enum logic [MODE_W-1:0] {
        MODE_INCREMENT = 3'd0,
        MODE_RESTORE   = 3'd1,
        MODE_SET       = 3'd2,
        MODE_RETARGET  = 3'd3,
        MODE_CLEAR     = 3'd4
    } mode_t;

    typedef struct packed {
        logic [COUNT_W-1:0] distance;
        logic               error;
        logic [IVAL_W-1:0]  interval;
        logic               sign;
        logic [MAG_W-1:0]   mag;
    } vok_state_t;

    typedef struct packed {
        logic short_write;
        logic long_write;
    } vok_pulse_t;

endpackage

/* design/vok_vote.sv */
// Two-of-three vote over the stored distance copies.
// An exact pair match wins first, then a match of the upper 24 bits.
// Depends on vok_pkg.
module vok_vote (
    input  logic [31:0] copy_a,
    input  logic [31:0] copy_b,
    input  logic [31:0] copy_c,
    output logic        found,
    output logic [23:0] pick
);
    import vok_pkg::*;

    logic a_ok;
    logic b_ok;

    assign a_ok = copy_a < COPY_LIMIT;
    assign b_ok = copy_b < COPY_LIMIT;

    always_comb
    begin
        found = 1'b1;
        pick  = copy_a[COUNT_W-1:0];
        if (copy_a == copy_b && a_ok)
        begin
            pick = copy_a[COUNT_W-1:0];
        end
        else if (copy_a == copy_c && a_ok)
        begin
            pick = copy_a[COUNT_W-1:0];
        end
        else if (copy_b == copy_c && b_ok)
        begin
            pick = copy_b[COUNT_W-1:0];
        end
        else if (copy_a[31:8] == copy_b[31:8] && a_ok)
        begin
            pick = copy_a[COUNT_W-1:0];
        end
        else if (copy_a[31:8] == copy_c[31:8] && a_ok)
        begin
            pick = copy_a[COUNT_W-1:0];
        end
        else if (copy_b[31:8] == copy_c[31:8] && b_ok)
        begin
            pick = copy_b[COUNT_W-1:0];
        end
        else
        begin
            found = 1'b0;
        end
    end

endmodule

/* design/vok_retarget.sv */
// New sign-magnitude offset for a retarget that keeps the total fixed.
// Starts from the stored offset word and moves it by the count change.
// Depends on vok_pkg.
module vok_retarget (
    input  logic [23:0] current,
    input  logic [23:0] target,
    input  logic [31:0] offset_word,
    output logic        sign,
    output logic [30:0] mag
);
    import vok_pkg::*;

    logic [WORD_W-1:0]  word;
    logic               word_sign;
    logic [MAG_W-1:0]   word_mag;
    logic               rising;
    logic [COUNT_W-1:0] diff;
    logic [MAG_W-1:0]   diff_ext;
    logic [WORD_W-1:0]  sum;
    logic [MAG_W-1:0]   sat_sum;

    assign word      = (offset_word == ALL_ONES) ? '0 : offset_word;
    assign word_sign = word[WORD_W-1];
    assign word_mag  = word[MAG_W-1:0];
    assign rising    = target >= current;
    assign diff      = rising ? (target - current) : (current - target);
    assign diff_ext  = {{(MAG_W-COUNT_W){1'b0}}, diff};
    assign sum       = {1'b0, word_mag} + {{(WORD_W-COUNT_W){1'b0}}, diff};
    assign sat_sum   = (sum > MAG_MAX) ? MAG_MAX[MAG_W-1:0] : sum[MAG_W-1:0];

    always_comb
    begin
        sign = word_sign;
        mag  = word_mag;
        if (word_sign == rising)
        begin
            // The count change works against the offset.
            if (word_mag > diff_ext)
            begin
                mag = word_mag - diff_ext;
            end
            else if (word_mag == diff_ext)
            begin
                mag  = '0;
                sign = 1'b0;
            end
            else
            begin
                mag  = diff_ext - word_mag;
                sign = ~word_sign;
            end
        end
        else
        begin
            mag = sat_sum;
        end
    end

endmodule

/* design/vok_update.sv */
// Next state and write request pulses for one command.
// Uses the copy vote and the retarget offset logic.
// Depends on vok_pkg, vok_vote and vok_retarget.
module vok_update (
    input  vok_pkg::vok_state_t state,
    input  logic [2:0]          mode,
    input  logic [23:0]         new_value,
    input  logic [31:0]         copy_a,
    input  logic [31:0]         copy_b,
    input  logic [31:0]         copy_c,
    input  logic [31:0]         stored_offset,
    input  logic [7:0]          long_interval,
    output vok_pkg::vok_state_t state_next,
    output vok_pkg::vok_pulse_t pulses
);
    import vok_pkg::*;

    logic               vote_found;
    logic [COUNT_W-1:0] vote_pick;
    logic               rt_sign;
    logic [MAG_W-1:0]   rt_mag;

    vok_vote u_vote (
        .copy_a (copy_a),
        .copy_b (copy_b),
        .copy_c (copy_c),
        .found  (vote_found),
        .pick   (vote_pick)
    );

    vok_retarget u_retarget (
        .current     (state.distance),
        .target      (new_value),
        .offset_word (stored_offset),
        .sign        (rt_sign),
        .mag         (rt_mag)
    );

    always_comb
    begin
        state_next = state;
        pulses     = '0;
        case (mode)
            MODE_INCREMENT:
            begin
                if (state.distance < COUNT_LIMIT && !state.error)
                begin
                    state_next.distance = state.distance + 1'b1;
                    pulses.short_write  = 1'b1;
                    if (state.interval < long_interval)
                    begin
                        state_next.interval = state.interval + 1'b1;
                    end
                    else
                    begin
                        state_next.interval = '0;
                        pulses.long_write   = 1'b1;
                    end
                end
            end
            MODE_RESTORE:
            begin
                if (vote_found)
                begin
                    state_next.distance = vote_pick;
                    state_next.error    = 1'b0;
                end
                else if (state.distance >= COUNT_LIMIT)
                begin
                    state_next.error = 1'b1;
                end
            end
            MODE_SET:
            begin
                state_next.distance = new_value;
                state_next.error    = 1'b0;
                pulses.long_write   = 1'b1;
            end
            MODE_RETARGET:
            begin
                state_next.distance = new_value;
                state_next.sign     = rt_sign;
                state_next.mag      = rt_mag;
                pulses.long_write   = 1'b1;
            end
            MODE_CLEAR:
            begin
                state_next.distance = '0;
                state_next.error    = 1'b0;
                pulses.long_write   = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

/* design/vok_total.sv */
// Offset-corrected total distance and its validity.
// A positive offset is subtracted from the count, a negative one added.
// Depends on vok_pkg.
module vok_total (
    input  vok_pkg::vok_state_t state,
    output logic                valid,
    output logic [23:0]         total
);
    import vok_pkg::*;

    logic [WORD_W-1:0] dist_ext;
    logic [WORD_W-1:0] mag_ext;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] remainder;

    assign dist_ext  = {{(WORD_W-COUNT_W){1'b0}}, state.distance};
    assign mag_ext   = {1'b0, state.mag};
    assign sum       = dist_ext + mag_ext;
    assign remainder = dist_ext - mag_ext;

    always_comb
    begin
        valid = 1'b1;
        total = '0;
        if (state.error)
        begin
            valid = 1'b0;
        end
        else if (state.sign)
        begin
            if (state.mag > NEG_MAG_LIMIT ||
                sum > {{(WORD_W-COUNT_W){1'b0}}, COUNT_LIMIT})
            begin
                valid = 1'b0;
            end
            else
            begin
                total = sum[COUNT_W-1:0];
            end
        end
        else
        begin
            if (dist_ext >= mag_ext)
            begin
                total = remainder[COUNT_W-1:0];
            end
            else
            begin
                valid = 1'b0;
            end
        end
    end

endmodule

/* design/voted_odometer_keeper.sv */
// Top level of the voted odometer keeper: stream ports, APB register and pipeline.
// Depends on vok_pkg, vok_update and vok_total.
//
// Each input transaction carries one command and yields exactly one result
// transaction. The block takes one transaction per clock cycle while the
// result stream is not stalled: a command is held in an input register, the
// whole state update and the corrected total are worked out from it, and the
// result is loaded into an output register once that register is free. The
// odometer state is updated together with the output register, so each
// command sees the state left by the one before it. The input side keeps
// accepting while a result waits, until both the input and output registers
// are full.
// The long write interval register (reset 10) lies at address 0 and should be
// written only while no transaction is in flight.
module voted_odometer_keeper (
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Command stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // new_value[23:0], copy_a[55:24], copy_b[87:56], copy_c[119:88],
    // stored_offset[151:120]
    input  logic [151:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]   s_tuser,
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_now[23:0], total_valid[24], total_distance[48:25], error_now[49],
    // short_write_request[50], long_write_request[51], offset_is_negative[52],
    // offset_size[83:53], zero fill[87:84]
    output logic [87:0]  m_tdata
);
    import vok_pkg::*;

    logic [IVAL_W-1:0]  long_interval_reg;
    logic               cfg_write;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [151:0]       in_data_reg;
    logic [2:0]         in_mode_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [87:0]        out_data_reg;
    logic [87:0]        out_data_next;

    vok_state_t         state_reg;
    vok_state_t         state_next;
    vok_pulse_t         pulses;
    logic               total_valid;
    logic [COUNT_W-1:0] total_distance;

    logic               s_accept;
    logic               out_free;
    logic               advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {24'd0, long_interval_reg} : 32'd0;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    vok_update u_update (
        .state         (state_reg),
        .mode          (in_mode_reg),
        .new_value     (in_data_reg[23:0]),
        .copy_a        (in_data_reg[55:24]),
        .copy_b        (in_data_reg[87:56]),
        .copy_c        (in_data_reg[119:88]),
        .stored_offset (in_data_reg[151:120]),
        .long_interval (long_interval_reg),
        .state_next    (state_next),
        .pulses        (pulses)
    );

    vok_total u_total (
        .state (state_next),
        .valid (total_valid),
        .total (total_distance)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_data_next = {4'd0, state_next.mag, state_next.sign, pulses.long_write,
                            pulses.short_write, state_next.error, total_distance,
                            total_valid, state_next.distance};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_interval_reg <= INTERVAL_RESET;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            state_reg         <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                long_interval_reg <= pwdata[IVAL_W-1:0];
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_data_reg <= s_tdata;
            in_mode_reg <= s_tuser;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
